// ===== sv/rcc_pkg.sv =====
package rcc_pkg;

   localparam int CFG_W_BITS    = 11;
   localparam int CFG_H_BITS    = 13;
   localparam int KERNEL_BITS   = 48;
   localparam int COEF_BITS     = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 48;
   localparam int CHAN_BITS     = 8;
   localparam int PIX_BITS      = 3 * CHAN_BITS;
   localparam int KERNEL_SIZE   = 3;
   localparam int TAPS          = KERNEL_SIZE * KERNEL_SIZE;
   localparam int CHANNELS      = 3;

   localparam int DEF_MAX_WIDTH      = 1024;
   localparam int DEF_COEF_FRAC_BITS = 8;
   localparam int OUT_FIFO_DEPTH     = 8;

   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_KERNEL_TOP    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_KERNEL_MIDDLE = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd4;

   localparam logic [CFG_W_BITS-1:0]  RESET_WIDTH       = 11'd1024;
   localparam logic [CFG_H_BITS-1:0]  RESET_HEIGHT      = 13'd1;
   localparam logic [KERNEL_BITS-1:0] RESET_KERNEL_EDGE = 48'h0;
   localparam logic [KERNEL_BITS-1:0] RESET_KERNEL_MID  = 48'h0000_0100_0000;

   typedef struct packed {
      logic valid;
      logic eof;
   } lane_ctl_type;

   // coefficient of one kernel column, left in the low bits
   function automatic logic signed [COEF_BITS-1:0] coef_of(
      input logic [KERNEL_BITS-1:0] word,
      input int                     col
   );
      coef_of = $signed(word[col*COEF_BITS +: COEF_BITS]);
   endfunction

endpackage

// ===== sv/rcc_line_buf.sv =====
module rcc_line_buf
   import rcc_pkg::*;
#(
   parameter int DEPTH     = 2 * DEF_MAX_WIDTH + 4,
   parameter int ADDR_BITS = $clog2(DEPTH)
)(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [PIX_BITS-1:0]  wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr_a,
   input  logic [ADDR_BITS-1:0] rd_addr_b,
   output logic [PIX_BITS-1:0]  rd_data_a,
   output logic [PIX_BITS-1:0]  rd_data_b
);

   logic [PIX_BITS-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

// ===== sv/rcc_lane.sv =====
module rcc_lane
   import rcc_pkg::*;
#(
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)(
   input  logic                        clock,
   input  logic                        reset,
   input  lane_ctl_type                in_ctl,
   input  logic [CHAN_BITS-1:0]        pix_in [TAPS],
   input  logic [TAPS-1:0]             tap_en,
   input  logic signed [COEF_BITS-1:0] coef [TAPS],
   output lane_ctl_type                out_ctl,
   output logic [CHAN_BITS-1:0]        chan_out
);

   localparam int PROD_BITS = CHAN_BITS + 1 + COEF_BITS;
   localparam int ROW_BITS  = PROD_BITS + 2;
   localparam int TOT_BITS  = PROD_BITS + 4;

   lane_ctl_type                ctl_a_ff, ctl_b_ff, ctl_c_ff;
   logic signed [PROD_BITS-1:0] pix_ext [TAPS];
   logic signed [PROD_BITS-1:0] coef_ext [TAPS];
   logic signed [PROD_BITS-1:0] prod_in [TAPS];
   logic signed [PROD_BITS-1:0] prod_ff [TAPS];
   logic signed [ROW_BITS-1:0]  row_in [KERNEL_SIZE];
   logic signed [ROW_BITS-1:0]  row_ff [KERNEL_SIZE];
   logic signed [TOT_BITS-1:0]  total;
   logic signed [TOT_BITS-1:0]  shifted;
   logic [CHAN_BITS-1:0]        chan_in;
   logic [CHAN_BITS-1:0]        chan_ff;

   // one multiplier per tap, disabled taps give zero
   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         pix_ext[k]  = PROD_BITS'({1'b0, pix_in[k]});
         coef_ext[k] = PROD_BITS'(coef[k]);
         prod_in[k]  = tap_en[k] ? pix_ext[k] * coef_ext[k] : '0;
      end
   end

   always_comb begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         row_in[r] = ROW_BITS'(prod_ff[3*r]) + ROW_BITS'(prod_ff[3*r+1])
                   + ROW_BITS'(prod_ff[3*r+2]);
      end
   end

   always_comb begin
      total   = TOT_BITS'(row_ff[0]) + TOT_BITS'(row_ff[1]) + TOT_BITS'(row_ff[2]);
      shifted = total >>> COEF_FRAC_BITS;
      if (total <= 0) begin
         chan_in = '0;
      end else if (shifted > TOT_BITS'(255)) begin
         chan_in = 8'd255;
      end else begin
         chan_in = shifted[CHAN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
      end else begin
         ctl_a_ff <= in_ctl;
         ctl_b_ff <= ctl_a_ff;
         ctl_c_ff <= ctl_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      row_ff  <= row_in;
      chan_ff <= chan_in;
   end

   assign out_ctl  = ctl_c_ff;
   assign chan_out = chan_ff;

endmodule

// ===== sv/rcc_out_fifo.sv =====
module rcc_out_fifo
   import rcc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  lane_ctl_type         push_ctl,
   input  logic [CHAN_BITS-1:0] push_red,
   input  logic [CHAN_BITS-1:0] push_green,
   input  logic [CHAN_BITS-1:0] push_blue,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [CHAN_BITS-1:0] rsp_red_out,
   output logic [CHAN_BITS-1:0] rsp_green_out,
   output logic [CHAN_BITS-1:0] rsp_blue_out,
   output logic                 rsp_end_of_frame
);

   localparam int PTR_BITS = $clog2(OUT_FIFO_DEPTH);
   localparam int CNT_BITS = $clog2(OUT_FIFO_DEPTH + 1);

   logic [PIX_BITS:0]   mem_ff [OUT_FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                pop;
   logic [PIX_BITS:0]   head;

   assign pop = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push_ctl.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(push_ctl.valid) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // the three lanes and the frame tag merge into one entry
   always_ff @(posedge clock) begin
      if (push_ctl.valid) begin
         mem_ff[wr_ptr_ff] <= {push_ctl.eof, push_blue, push_green, push_red};
      end
   end

   assign head             = mem_ff[rd_ptr_ff];
   assign rsp_valid        = (count_ff != '0);
   assign rsp_red_out      = head[CHAN_BITS-1:0];
   assign rsp_green_out    = head[2*CHAN_BITS-1:CHAN_BITS];
   assign rsp_blue_out     = head[3*CHAN_BITS-1:2*CHAN_BITS];
   assign rsp_end_of_frame = head[PIX_BITS];

endmodule

// ===== sv/rgb_3x3_convolution_clamp.sv =====
// 3x3 convolution of an RGB888 raster stream with signed Q8.8 coefficients, zero padded at
// the image border, each channel truncated and clamped to 0..255. One item (pixel or flush)
// is taken every clock while req_stall is low. A result passes from the item that completes
// its window through line-buffer read, window shift, multiply, row sums, final sum and clamp,
// then an eight-entry result queue; when that queue plus the results in flight reach eight,
// req_stall rises until results are taken. Results trail the input by one row plus one pixel,
// so after the last pixel of a frame width+1 flush items drain the rest. The line buffer holds
// 2*MAX_WIDTH+4 pixels with one write and two reads per cycle; it needs no clearing after reset.
module rgb_3x3_convolution_clamp
   import rcc_pkg::*;
#(
   parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CHAN_BITS-1:0]     req_red_in,
   input  logic [CHAN_BITS-1:0]     req_green_in,
   input  logic [CHAN_BITS-1:0]     req_blue_in,
   input  logic                     req_flush,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CHAN_BITS-1:0]     rsp_red_out,
   output logic [CHAN_BITS-1:0]     rsp_green_out,
   output logic [CHAN_BITS-1:0]     rsp_blue_out,
   output logic                     rsp_end_of_frame,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int LINE_DEPTH = 2 * MAX_WIDTH + 4;
   localparam int LA         = $clog2(LINE_DEPTH);
   localparam int LA1        = LA + 1;
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int HB         = CFG_H_BITS;
   localparam int HB1        = HB + 1;
   localparam int CNT        = WW + HB;
   localparam int CNT1       = CNT + 1;
   localparam int OCC_BITS   = $clog2(OUT_FIFO_DEPTH + 1);

   typedef struct packed {
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
      logic eof;
   } edge_type;

   // configuration
   logic [CFG_W_BITS-1:0]  width_ff, width_in;
   logic [CFG_H_BITS-1:0]  height_ff, height_in;
   logic [KERNEL_BITS-1:0] ktop_ff, ktop_in, kmid_ff, kmid_in, kbot_ff, kbot_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      ktop_in   = ktop_ff;
      kmid_in   = kmid_ff;
      kbot_in   = kbot_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH:   width_in  = csr_wdata[CFG_W_BITS-1:0];
            REG_IMAGE_HEIGHT:  height_in = csr_wdata[CFG_H_BITS-1:0];
            REG_KERNEL_TOP:    ktop_in   = csr_wdata[KERNEL_BITS-1:0];
            REG_KERNEL_MIDDLE: kmid_in   = csr_wdata[KERNEL_BITS-1:0];
            REG_KERNEL_BOTTOM: kbot_in   = csr_wdata[KERNEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         ktop_ff   <= RESET_KERNEL_EDGE;
         kmid_ff   <= RESET_KERNEL_MID;
         kbot_ff   <= RESET_KERNEL_EDGE;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         ktop_ff   <= ktop_in;
         kmid_ff   <= kmid_in;
         kbot_ff   <= kbot_in;
      end
   end

   logic [31:0]   w_raw;
   logic [WW-1:0] w_eff;
   logic [HB-1:0] h_eff;
   logic [CNT-1:0] w_cnt, h_cnt, total;

   always_comb begin
      w_raw = 32'(width_ff);
      if (w_raw == 32'd0) begin
         w_raw = 32'd1;
      end else if (w_raw > 32'(MAX_WIDTH)) begin
         w_raw = 32'(MAX_WIDTH);
      end
      w_eff = w_raw[WW-1:0];
      h_eff = (height_ff == '0) ? HB'(1) : height_ff;
      w_cnt = CNT'(w_eff);
      h_cnt = CNT'(h_eff);
      total = w_cnt * h_cnt;
   end

   // frame position counters
   logic [CW-1:0]  col_ff, col_in, ocol_ff, ocol_in;
   logic [HB-1:0]  row_ff, row_in, orow_ff, orow_in;
   logic [CNT-1:0] in_cnt_ff, in_cnt_in, out_cnt_ff, out_cnt_in;
   logic [LA-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OCC_BITS-1:0] occ_ff, occ_in;
   logic [PIX_BITS-1:0] prev_pix_ff, prev_pix_in;

   logic           accept, restart, complete_cur, complete_new, wr, ready, eof, first;
   logic [CW-1:0]  cur_col, cur_ocol, new_col;
   logic [HB-1:0]  cur_row, cur_orow, new_row;
   logic [CNT-1:0] cur_in, cur_out, new_in, col_plus, ocol_plus;
   logic [LA-1:0]  cur_wr, cur_rd, wr_next, rd_next, rd_addr_a;
   logic [LA1-1:0] top_addr;
   logic [CNT1-1:0] need;
   logic [PIX_BITS-1:0] pix;
   edge_type       edges;
   logic           pop;

   assign accept = req_valid && !req_stall;
   assign pix    = {req_blue_in, req_green_in, req_red_in};
   assign pop    = rsp_valid && !rsp_stall;

   always_comb begin
      restart  = (row_ff >= h_eff) && (out_cnt_ff >= total);
      cur_col  = restart ? '0 : col_ff;
      cur_row  = restart ? '0 : row_ff;
      cur_in   = restart ? '0 : in_cnt_ff;
      cur_wr   = restart ? '0 : wr_ptr_ff;
      cur_out  = restart ? '0 : out_cnt_ff;
      cur_ocol = restart ? '0 : ocol_ff;
      cur_orow = restart ? '0 : orow_ff;
      cur_rd   = restart ? LA'(1) : rd_ptr_ff;

      // pixel side
      complete_cur = cur_row >= h_eff;
      wr       = !req_flush && !complete_cur;
      col_plus = CNT'(cur_col) + 1'b1;
      wr_next  = (cur_wr == LA'(LINE_DEPTH - 1)) ? '0 : cur_wr + 1'b1;
      new_col  = cur_col;
      new_row  = cur_row;
      new_in   = cur_in;
      if (wr) begin
         new_in = cur_in + 1'b1;
         if (col_plus >= w_cnt) begin
            new_col = '0;
            new_row = cur_row + 1'b1;
         end else begin
            new_col = col_plus[CW-1:0];
         end
      end
      complete_new = new_row >= h_eff;

      // result side: ready once the pixel right below-right of it is in
      need  = CNT1'(cur_out) + CNT1'(w_eff) + CNT1'(2);
      ready = (cur_out < total) && (complete_new || CNT1'(new_in) >= need);
      first = (cur_out == '0);
      eof   = (CNT1'(cur_out) + 1'b1) >= CNT1'(total);
      ocol_plus = CNT'(cur_ocol) + 1'b1;
      rd_next   = (cur_rd == LA'(LINE_DEPTH - 1)) ? '0 : cur_rd + 1'b1;

      edges.top_ok   = (cur_orow != '0);
      edges.bot_ok   = (HB1'(cur_orow) + 1'b1) < HB1'(h_eff);
      edges.left_ok  = (cur_ocol != '0);
      edges.right_ok = ocol_plus < w_cnt;
      edges.eof      = eof;

      // row above, modulo the history depth
      if (LA1'(cur_rd) >= LA1'(w_eff)) begin
         top_addr = LA1'(cur_rd) - LA1'(w_eff);
      end else begin
         top_addr = LA1'(cur_rd) + LA1'(LINE_DEPTH) - LA1'(w_eff);
      end
      // first result of a frame loads two columns: pixel 0 and pixel 1
      rd_addr_a = first ? '0 : top_addr[LA-1:0];

      col_in     = col_ff;
      row_in     = row_ff;
      in_cnt_in  = in_cnt_ff;
      wr_ptr_in  = wr_ptr_ff;
      out_cnt_in = out_cnt_ff;
      ocol_in    = ocol_ff;
      orow_in    = orow_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (accept) begin
         if (ready && eof) begin
            col_in     = '0;
            row_in     = '0;
            in_cnt_in  = '0;
            wr_ptr_in  = '0;
            out_cnt_in = '0;
            ocol_in    = '0;
            orow_in    = '0;
            rd_ptr_in  = LA'(1);
         end else begin
            col_in    = new_col;
            row_in    = new_row;
            in_cnt_in = new_in;
            wr_ptr_in = wr ? wr_next : cur_wr;
            if (ready) begin
               out_cnt_in = cur_out + 1'b1;
               rd_ptr_in  = rd_next;
               if (ocol_plus >= w_cnt) begin
                  ocol_in = '0;
                  orow_in = cur_orow + 1'b1;
               end else begin
                  ocol_in = ocol_plus[CW-1:0];
                  orow_in = cur_orow;
               end
            end else begin
               out_cnt_in = cur_out;
               ocol_in    = cur_ocol;
               orow_in    = cur_orow;
               rd_ptr_in  = cur_rd;
            end
         end
      end

      prev_pix_in = (accept && wr) ? pix : prev_pix_ff;
      occ_in = occ_ff + OCC_BITS'(accept && ready) - OCC_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         in_cnt_ff  <= '0;
         wr_ptr_ff  <= '0;
         out_cnt_ff <= '0;
         ocol_ff    <= '0;
         orow_ff    <= '0;
         rd_ptr_ff  <= LA'(1);
         occ_ff     <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         in_cnt_ff  <= in_cnt_in;
         wr_ptr_ff  <= wr_ptr_in;
         out_cnt_ff <= out_cnt_in;
         ocol_ff    <= ocol_in;
         orow_ff    <= orow_in;
         rd_ptr_ff  <= rd_ptr_in;
         occ_ff     <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_pix_ff <= prev_pix_in;
   end

   // results in flight plus queued never exceed the queue depth
   assign req_stall = (occ_ff >= OCC_BITS'(OUT_FIFO_DEPTH));

   logic [PIX_BITS-1:0] line_a, line_b;

   rcc_line_buf #(
      .DEPTH     (LINE_DEPTH),
      .ADDR_BITS (LA)
   ) u_line_buf (
      .clock     (clock),
      .wr_en     (accept && wr),
      .wr_addr   (cur_wr),
      .wr_data   (pix),
      .rd_en     (accept && ready),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (cur_rd),
      .rd_data_a (line_a),
      .rd_data_b (line_b)
   );

   // stage 1: line buffer data arrives
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_first_ff, s1_first_in;
   edge_type            s1_edges_ff, s1_edges_in;
   logic [PIX_BITS-1:0] s1_bot_ff, s1_bot_in;
   logic [PIX_BITS-1:0] s1_prev_ff, s1_prev_in;
   logic                s1_hit_a_ff, s1_hit_a_in;
   logic                s1_hit_b_ff, s1_hit_b_in;

   always_comb begin
      s1_valid_in = accept && ready;
      s1_first_in = first;
      s1_edges_in = edges;
      s1_bot_in   = pix;
      // in a two-row, one-column frame the pixel below the first result is the one arriving now
      s1_prev_in  = (wr && (cur_in == w_cnt)) ? pix : prev_pix_ff;
      // a read of the address written in the same cycle takes the arriving pixel
      s1_hit_a_in = accept && wr && (rd_addr_a == cur_wr);
      s1_hit_b_in = accept && wr && (cur_rd == cur_wr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= s1_first_in;
      s1_edges_ff <= s1_edges_in;
      s1_bot_ff   <= s1_bot_in;
      s1_prev_ff  <= s1_prev_in;
      s1_hit_a_ff <= s1_hit_a_in;
      s1_hit_b_ff <= s1_hit_b_in;
   end

   // stage 2: window, indexed [column][row]
   logic [PIX_BITS-1:0] win_ff [KERNEL_SIZE][KERNEL_SIZE];
   logic [PIX_BITS-1:0] win_in [KERNEL_SIZE][KERNEL_SIZE];
   logic                s2_valid_ff, s2_valid_in;
   edge_type            s2_edges_ff, s2_edges_in;
   logic [PIX_BITS-1:0] col_a, col_b;

   always_comb begin
      col_a       = s1_hit_a_ff ? s1_bot_ff : line_a;
      col_b       = s1_hit_b_ff ? s1_bot_ff : line_b;
      win_in      = win_ff;
      s2_valid_in = s1_valid_ff;
      s2_edges_in = s1_edges_ff;
      if (s1_valid_ff) begin
         if (s1_first_ff) begin
            // top row is off the image for the first row of results; with a one-pixel
            // width the top of the next column is pixel 0
            win_in[1][0] = '0;
            win_in[1][1] = col_a;
            win_in[1][2] = s1_prev_ff;
            win_in[2][0] = col_a;
            win_in[2][1] = col_b;
            win_in[2][2] = s1_bot_ff;
         end else begin
            win_in[0]    = win_ff[1];
            win_in[1]    = win_ff[2];
            win_in[2][0] = col_a;
            win_in[2][1] = col_b;
            win_in[2][2] = s1_bot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      s2_edges_ff <= s2_edges_in;
   end

   // tap enables and coefficients, tap k = row * 3 + column
   logic [TAPS-1:0]             tap_en;
   logic signed [COEF_BITS-1:0] coef [TAPS];
   logic [KERNEL_BITS-1:0]      kword;
   logic                        row_ok, col_ok;

   always_comb begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            kword  = (r == 0) ? ktop_ff : ((r == 1) ? kmid_ff : kbot_ff);
            row_ok = (r == 0) ? s2_edges_ff.top_ok : ((r == 2) ? s2_edges_ff.bot_ok : 1'b1);
            col_ok = (c == 0) ? s2_edges_ff.left_ok : ((c == 2) ? s2_edges_ff.right_ok : 1'b1);
            tap_en[r*KERNEL_SIZE+c] = row_ok && col_ok;
            coef[r*KERNEL_SIZE+c]   = coef_of(kword, c);
         end
      end
   end

   lane_ctl_type         lane_in_ctl;
   lane_ctl_type         lane_out_ctl [CHANNELS];
   logic [CHAN_BITS-1:0] lane_out [CHANNELS];

   assign lane_in_ctl.valid = s2_valid_ff;
   assign lane_in_ctl.eof   = s2_edges_ff.eof;

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      logic [CHAN_BITS-1:0] lane_pix [TAPS];

      always_comb begin
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int c = 0; c < KERNEL_SIZE; c++) begin
               lane_pix[r*KERNEL_SIZE+c] = win_ff[c][r][ch*CHAN_BITS +: CHAN_BITS];
            end
         end
      end

      rcc_lane #(
         .COEF_FRAC_BITS (COEF_FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .in_ctl   (lane_in_ctl),
         .pix_in   (lane_pix),
         .tap_en   (tap_en),
         .coef     (coef),
         .out_ctl  (lane_out_ctl[ch]),
         .chan_out (lane_out[ch])
      );
   end

   rcc_out_fifo u_out_fifo (
      .clock            (clock),
      .reset            (reset),
      .push_ctl         (lane_out_ctl[0]),
      .push_red         (lane_out[0]),
      .push_green       (lane_out[1]),
      .push_blue        (lane_out[2]),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule

// ===== sv/rcc_checker.sv =====
module rcc_checker
   import rcc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [CHAN_BITS-1:0]     req_red_in,
   input logic [CHAN_BITS-1:0]     req_green_in,
   input logic [CHAN_BITS-1:0]     req_blue_in,
   input logic                     req_flush,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [CHAN_BITS-1:0]     rsp_red_out,
   input logic [CHAN_BITS-1:0]     rsp_green_out,
   input logic [CHAN_BITS-1:0]     rsp_blue_out,
   input logic                     rsp_end_of_frame,
   input logic                     csr_wr_en,
   input logic [CSR_IDX_BITS-1:0]  csr_index,
   input logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // queue starts empty, so results and backpressure are both clear after reset
   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_stall_after_reset: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_red_out) && $stable(rsp_green_out)
         && $stable(rsp_blue_out) && $stable(rsp_end_of_frame))
      else $error("stalled result changed");

endmodule

bind rgb_3x3_convolution_clamp rcc_checker u_rcc_checker (.*);
